// ----- hdl/nrb_pkg.sv -----
// ----------------------------------------------------------------------------
// nrb_pkg: shared types and constants for the n-gram repeat ban block
// Token width, control structs and sequencer states used by the cell chain,
// the result stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package nrb_pkg;

  localparam int unsigned TokW       = 18;
  localparam int unsigned NgramW     = 4;
  localparam int unsigned MaxStepsDef = 64;
  localparam logic [NgramW-1:0] NgramRst = 4'd3;

  typedef logic [TokW-1:0] tok_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift;  // move tokens and hits one cell up
    logic init;   // load window copy and window-valid flag
    logic cmp;    // compare window copy with key, advance copy
  } cell_ctrl_t;

  // request to the result stage
  typedef struct packed {
    logic push;   // a banned token is offered
    logic fin;    // close the row
  } res_req_t;

  // answer of the result stage
  typedef struct packed {
    logic push_ok;
    logic fin_ok;
  } res_sts_t;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_INIT = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/nrb_cell.sv -----
// ----------------------------------------------------------------------------
// nrb_cell: one token cell of the ban chain
// Holds one stored token, a sliding copy of a later token for the key compare
// and a hit flag that marks its token as banned.
// ----------------------------------------------------------------------------
`default_nettype none

module nrb_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned LimW    = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  nrb_pkg::cell_ctrl_t  ctrl_i,
  input  nrb_pkg::tok_t        key_i,
  input  wire                  win_ok_i,
  input  wire [LimW-1:0]       win_top_i,
  input  nrb_pkg::tok_t        prev_tok_i,
  input  wire                  prev_hit_i,
  input  nrb_pkg::tok_t        next_tok_i,
  input  nrb_pkg::tok_t        next_win_i,
  output nrb_pkg::tok_t        tok_o,
  output nrb_pkg::tok_t        win_o,
  output logic                 hit_o
);

  nrb_pkg::tok_t tok_q, tok_d;
  nrb_pkg::tok_t win_q, win_d;
  logic          hit_q, hit_d;
  logic          in_range;

  assign in_range = win_ok_i && (LimW'(CellIdx) <= win_top_i);

  always_comb begin
    tok_d = tok_q;
    win_d = win_q;
    hit_d = hit_q;
    if (ctrl_i.init) begin
      win_d = next_tok_i;
      hit_d = in_range;
    end else if (ctrl_i.cmp) begin
      win_d = next_win_i;
      hit_d = hit_q && (win_q == key_i);
    end else if (ctrl_i.shift) begin
      tok_d = prev_tok_i;
      hit_d = prev_hit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    win_q <= win_d;
  end

  assign tok_o = tok_q;
  assign win_o = win_q;
  assign hit_o = hit_q;

endmodule

`default_nettype wire

// ----- hdl/nrb_res.sv -----
// ----------------------------------------------------------------------------
// nrb_res: result stage of the ban chain
// Holds one banned token back so the final beat of a row carries last, and
// drives the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nrb_res (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  nrb_pkg::res_req_t  req_i,
  input  nrb_pkg::tok_t      tok_i,
  output nrb_pkg::res_sts_t  sts_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output nrb_pkg::tok_t      ban_tok_o,
  output logic               has_ban_o,
  output logic               last_result_o
);

  logic          pend_vld_q, pend_vld_d;
  nrb_pkg::tok_t pend_tok_q;
  logic          out_vld_q, out_vld_d;
  nrb_pkg::tok_t out_tok_q;
  logic          out_has_q;
  logic          out_last_q;
  logic          out_free;
  logic          push_go;
  logic          fin_go;
  logic          out_load;

  assign out_free      = !out_vld_q || out_ready_i;
  assign sts_o.push_ok = !pend_vld_q || out_free;
  assign sts_o.fin_ok  = out_free;
  assign push_go       = req_i.push && sts_o.push_ok;
  assign fin_go        = req_i.fin && out_free;
  assign out_load      = (push_go && pend_vld_q) || fin_go;

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (push_go) begin
      pend_vld_d = 1'b1;
    end else if (fin_go) begin
      pend_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q && !out_ready_i;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_go) begin
      pend_tok_q <= tok_i;
    end
    if (out_load) begin
      out_tok_q  <= pend_vld_q ? pend_tok_q : '0;
      out_has_q  <= pend_vld_q;
      out_last_q <= fin_go;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign ban_tok_o      = out_tok_q;
  assign has_ban_o      = out_has_q;
  assign last_result_o  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/no_repeat_ngram_ban.sv -----
// ----------------------------------------------------------------------------
// no_repeat_ngram_ban: n-gram repeat ban for one beam row at a time
// Tokens shift into a chain of cells; after the last token the chain matches
// every earlier window against the key and streams out the banned tokens.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i/in_ready_o   | token_i, last_i
//  out     | source    | out_valid_o/out_ready_i | ban_tok_o, has_ban_o,
//          |           |                         | last_result_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | ngram_size_i
//
//  Tokens load at one beat per cycle. After the last token the row runs an
//  init step, the compare sweep and the scan that shifts every cell past the
//  top of the chain, then closes the row; a stalled output holds the scan and
//  the close. Input is not taken until the row's final beat is queued.
//  Reset clears the control state and the token count; cell tokens are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module no_repeat_ngram_ban #(
  parameter int unsigned MaxSteps = nrb_pkg::MaxStepsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [nrb_pkg::TokW-1:0]     token_i,
  input  wire                         last_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [nrb_pkg::TokW-1:0]    ban_tok_o,
  output logic                        has_ban_o,
  output logic                        last_result_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [nrb_pkg::NgramW-1:0]   ngram_size_i
);

  localparam int unsigned CntW     = $clog2(MaxSteps + 1);
  localparam int unsigned IdxW     = $clog2(MaxSteps);
  localparam int unsigned CmpW     = ((CntW > nrb_pkg::NgramW) ? CntW : nrb_pkg::NgramW) + 1;
  localparam int unsigned KeyCells = (MaxSteps < 15) ? MaxSteps : 15;

  nrb_pkg::state_e            state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [nrb_pkg::NgramW-1:0] m_q, m_d;
  logic [IdxW-1:0]            sc_q, sc_d;
  logic [nrb_pkg::NgramW-1:0] ngram_size_q;
  logic [nrb_pkg::NgramW-1:0] n_eff;
  logic [CmpW-1:0]            count_ext;
  logic [CmpW-1:0]            n_ext;
  logic                       win_ok;
  logic [CmpW-1:0]            win_top;
  logic                       in_fire;
  logic                       top_hit;
  nrb_pkg::tok_t              key;
  nrb_pkg::cell_ctrl_t        cell_ctrl;
  nrb_pkg::res_req_t          res_req;
  nrb_pkg::res_sts_t          res_sts;

  nrb_pkg::tok_t              tok [MaxSteps];
  nrb_pkg::tok_t              win [MaxSteps];
  logic                       hit [MaxSteps];

  assign cfg_ready_o = (state_q == nrb_pkg::ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ngram_size_q <= nrb_pkg::NgramRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ngram_size_q <= ngram_size_i;
    end
  end

  assign n_eff     = (ngram_size_q == '0) ? nrb_pkg::NgramW'(1) : ngram_size_q;
  assign count_ext = CmpW'(count_q);
  assign n_ext     = CmpW'(n_eff);
  assign win_ok    = count_ext >= n_ext;
  assign win_top   = count_ext - n_ext;

  assign in_ready_o = (state_q == nrb_pkg::ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign top_hit    = hit[MaxSteps-1];

  always_comb begin
    key = '0;
    for (int k = 0; k < KeyCells; k++) begin
      if (m_q == nrb_pkg::NgramW'(k)) begin
        key = tok[k];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    m_d       = m_q;
    sc_d      = sc_q;
    cell_ctrl = '0;
    res_req   = '0;
    case (state_q)
      nrb_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (count_q < CntW'(MaxSteps)) begin
            cell_ctrl.shift = 1'b1;
            count_d         = count_q + 1'b1;
          end
          if (last_i) begin
            state_d = nrb_pkg::ST_INIT;
          end
        end
      end
      nrb_pkg::ST_INIT: begin
        cell_ctrl.init = 1'b1;
        count_d        = '0;
        m_d            = '0;
        sc_d           = '0;
        state_d        = (n_eff == nrb_pkg::NgramW'(1)) ? nrb_pkg::ST_SCAN : nrb_pkg::ST_CMP;
      end
      nrb_pkg::ST_CMP: begin
        cell_ctrl.cmp = 1'b1;
        m_d           = m_q + 1'b1;
        if (m_q == n_eff - nrb_pkg::NgramW'(2)) begin
          state_d = nrb_pkg::ST_SCAN;
        end
      end
      nrb_pkg::ST_SCAN: begin
        res_req.push = top_hit;
        if (!top_hit || res_sts.push_ok) begin
          cell_ctrl.shift = 1'b1;
          sc_d            = sc_q + 1'b1;
          if (sc_q == IdxW'(MaxSteps - 1)) begin
            state_d = nrb_pkg::ST_DONE;
          end
        end
      end
      nrb_pkg::ST_DONE: begin
        res_req.fin = 1'b1;
        if (res_sts.fin_ok) begin
          state_d = nrb_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = nrb_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrb_pkg::ST_LOAD;
      count_q <= '0;
      m_q     <= '0;
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      m_q     <= m_d;
      sc_q    <= sc_d;
    end
  end

  for (genvar j = 0; j < MaxSteps; j++) begin : g_cell
    nrb_pkg::tok_t prev_tok;
    logic          prev_hit;
    nrb_pkg::tok_t next_tok;
    nrb_pkg::tok_t next_win;

    if (j == 0) begin : g_first
      assign prev_tok = token_i;
      assign prev_hit = 1'b0;
    end else begin : g_mid
      assign prev_tok = tok[j-1];
      assign prev_hit = hit[j-1];
    end

    if (j == MaxSteps - 1) begin : g_top
      assign next_tok = '0;
      assign next_win = '0;
    end else begin : g_below
      assign next_tok = tok[j+1];
      assign next_win = win[j+1];
    end

    nrb_cell #(
      .CellIdx (j),
      .LimW    (CmpW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .key_i      (key),
      .win_ok_i   (win_ok),
      .win_top_i  (win_top),
      .prev_tok_i (prev_tok),
      .prev_hit_i (prev_hit),
      .next_tok_i (next_tok),
      .next_win_i (next_win),
      .tok_o      (tok[j]),
      .win_o      (win[j]),
      .hit_o      (hit[j])
    );
  end

  nrb_res u_res (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (res_req),
    .tok_i          (tok[MaxSteps-1]),
    .sts_o          (res_sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ban_tok_o      (ban_tok_o),
    .has_ban_o      (has_ban_o),
    .last_result_o  (last_result_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSteps))
    else $error("token count above chain depth");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_ban_o) |-> last_result_o)
    else $error("none beat without last");

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrb_pkg::ST_SCAN && top_hit && !res_sts.push_ok) |=> $stable(sc_q))
    else $error("scan advanced over a blocked hit");

  a_row_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrb_pkg::ST_DONE && res_sts.fin_ok) |=> (in_ready_o && count_q == '0))
    else $error("row close did not return to load");

endmodule

`default_nettype wire
